### hw/rtl/itr_pkg.sv
`timescale 1ns / 1ps

package itr_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned SymW   = 8;

  localparam logic [ValueW-1:0] VALUE_MAX = 12'd3999;
  localparam logic [IdxW-1:0]   IDX_TOP   = 4'd12;

  localparam logic [SymW-1:0] CH_NONE = 8'h00;
  localparam logic [SymW-1:0] CH_I    = 8'h49;
  localparam logic [SymW-1:0] CH_V    = 8'h56;
  localparam logic [SymW-1:0] CH_X    = 8'h58;
  localparam logic [SymW-1:0] CH_L    = 8'h4C;
  localparam logic [SymW-1:0] CH_C    = 8'h43;
  localparam logic [SymW-1:0] CH_D    = 8'h44;
  localparam logic [SymW-1:0] CH_M    = 8'h4D;

  // Microprogram addresses
  typedef logic [2:0] upc_t;
  localparam upc_t UPC_IDLE   = 3'd0;
  localparam upc_t UPC_TEST   = 3'd1;
  localparam upc_t UPC_FIRST  = 3'd2;
  localparam upc_t UPC_SECOND = 3'd3;
  localparam upc_t UPC_FLUSH  = 3'd4;
  localparam upc_t UPC_FLAG   = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_TEST,
    OP_FIRST,
    OP_SECOND,
    OP_FLUSH,
    OP_FLAG
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_SPECIAL,
    COND_REM_ZERO,
    COND_FITS,
    COND_HAS_SECOND
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond_a;
    upc_t  tgt_a;
    cond_e cond_b;
    upc_t  tgt_b;
    upc_t  nxt;
  } uword_t;

  // Request from the sequencer to the output stage
  typedef struct packed {
    logic            char_vld;
    logic            flush;
    logic            flag;
    logic            oor;
    logic [SymW-1:0] sym;
  } emit_req_t;

  typedef struct packed {
    logic char_rdy;
    logic res_rdy;
  } emit_rdy_t;

  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    unique case (pc)
      UPC_IDLE:   w = '{OP_LOAD,   COND_SPECIAL,    UPC_FLAG,
                        COND_NEVER,    UPC_IDLE,  UPC_TEST};
      UPC_TEST:   w = '{OP_TEST,   COND_REM_ZERO,   UPC_FLUSH,
                        COND_FITS,     UPC_FIRST, UPC_TEST};
      UPC_FIRST:  w = '{OP_FIRST,  COND_HAS_SECOND, UPC_SECOND,
                        COND_NEVER,    UPC_IDLE,  UPC_TEST};
      UPC_SECOND: w = '{OP_SECOND, COND_NEVER,      UPC_IDLE,
                        COND_NEVER,    UPC_IDLE,  UPC_TEST};
      UPC_FLUSH:  w = '{OP_FLUSH,  COND_NEVER,      UPC_IDLE,
                        COND_NEVER,    UPC_IDLE,  UPC_IDLE};
      UPC_FLAG:   w = '{OP_FLAG,   COND_NEVER,      UPC_IDLE,
                        COND_NEVER,    UPC_IDLE,  UPC_IDLE};
      default:    w = '{OP_NOP,    COND_NEVER,      UPC_IDLE,
                        COND_NEVER,    UPC_IDLE,  UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [9:0] tbl_val(logic [IdxW-1:0] idx);
    logic [9:0] v;
    unique case (idx)
      4'd0:    v = 10'd1;
      4'd1:    v = 10'd4;
      4'd2:    v = 10'd5;
      4'd3:    v = 10'd9;
      4'd4:    v = 10'd10;
      4'd5:    v = 10'd40;
      4'd6:    v = 10'd50;
      4'd7:    v = 10'd90;
      4'd8:    v = 10'd100;
      4'd9:    v = 10'd400;
      4'd10:   v = 10'd500;
      4'd11:   v = 10'd900;
      default: v = 10'd1000;
    endcase
    return v;
  endfunction

  function automatic logic [SymW-1:0] tbl_first(logic [IdxW-1:0] idx);
    logic [SymW-1:0] c;
    unique case (idx)
      4'd0, 4'd1, 4'd3:  c = CH_I;
      4'd2:              c = CH_V;
      4'd4, 4'd5, 4'd7:  c = CH_X;
      4'd6:              c = CH_L;
      4'd8, 4'd9, 4'd11: c = CH_C;
      4'd10:             c = CH_D;
      default:           c = CH_M;
    endcase
    return c;
  endfunction

  function automatic logic [SymW-1:0] tbl_second(logic [IdxW-1:0] idx);
    logic [SymW-1:0] c;
    unique case (idx)
      4'd1:    c = CH_V;
      4'd3:    c = CH_X;
      4'd5:    c = CH_L;
      4'd7:    c = CH_C;
      4'd9:    c = CH_D;
      4'd11:   c = CH_M;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/itr_out_stage.sv
`timescale 1ns / 1ps

module itr_out_stage import itr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  emit_req_t       req_i,
  output emit_rdy_t       rdy_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SymW-1:0] symbol_o,
  output logic            last_o,
  output logic            no_symbol_o,
  output logic            out_of_range_o
);

  logic            hold_vld_q, hold_vld_d;
  logic [SymW-1:0] hold_sym_q, hold_sym_d;
  logic            out_vld_q, out_vld_d;
  logic [SymW-1:0] sym_q, sym_d;
  logic            last_q, last_d;
  logic            nosym_q, nosym_d;
  logic            oor_q, oor_d;
  logic            out_free;

  assign out_free       = !out_vld_q || out_ready_i;
  assign rdy_o.char_rdy = !hold_vld_q || out_free;
  assign rdy_o.res_rdy  = out_free;

  always_comb begin
    hold_vld_d = hold_vld_q;
    hold_sym_d = hold_sym_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    sym_d      = sym_q;
    last_d     = last_q;
    nosym_d    = nosym_q;
    oor_d      = oor_q;
    if (req_i.char_vld && rdy_o.char_rdy) begin
      // Push the held character on; it is not the last one
      if (hold_vld_q) begin
        out_vld_d = 1'b1;
        sym_d     = hold_sym_q;
        last_d    = 1'b0;
        nosym_d   = 1'b0;
        oor_d     = 1'b0;
      end
      hold_vld_d = 1'b1;
      hold_sym_d = req_i.sym;
    end else if (req_i.flush && out_free) begin
      out_vld_d  = 1'b1;
      sym_d      = hold_sym_q;
      last_d     = 1'b1;
      nosym_d    = 1'b0;
      oor_d      = 1'b0;
      hold_vld_d = 1'b0;
    end else if (req_i.flag && out_free) begin
      out_vld_d = 1'b1;
      sym_d     = CH_NONE;
      last_d    = 1'b1;
      nosym_d   = 1'b1;
      oor_d     = req_i.oor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_sym_q <= hold_sym_d;
    sym_q      <= sym_d;
    last_q     <= last_d;
    nosym_q    <= nosym_d;
    oor_q      <= oor_d;
  end

  assign out_valid_o    = out_vld_q;
  assign symbol_o       = sym_q;
  assign last_o         = last_q;
  assign no_symbol_o    = nosym_q;
  assign out_of_range_o = oor_q;

endmodule

### hw/rtl/integer_to_roman.sv
`timescale 1ns / 1ps

// Integer to Roman numeral converter.
// Input channel (in_valid_i / in_ready_o / value_i): one 12-bit unsigned
// integer per item. Output channel (out_valid_o / out_ready_i): one ASCII
// character per item in symbol_o, with last_o on the final character of a run.
// Zero gives a single item with no_symbol_o set; a value above 3999 gives a
// single item with no_symbol_o and out_of_range_o set.
// A small microprogram in a read-only table steps through load, table test,
// first and second character, flush and flag words, one word per cycle while
// no word stalls. The table index walks down from 1000 to 1, and each symbol
// group takes a test word plus one word per character; in_ready_o is high
// only in the idle word. The newest character is held back in a holding
// register so that last_o can be set on it once the run is known to end; the
// output register frees the datapath from the receiver. When the output stage
// cannot take a request the sequencer stalls on its current word and nothing
// is dropped. Reset returns the sequencer to idle and empties the output
// stage; no result is pending afterwards.

module integer_to_roman import itr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SymW-1:0]   symbol_o,
  output logic              last_o,
  output logic              no_symbol_o,
  output logic              out_of_range_o
);

  upc_t              upc_q, upc_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              oor_q, oor_d;

  uword_t            uw;
  logic              go;
  logic              take_a, take_b;
  logic              special;
  logic              fits;
  logic [ValueW-1:0] tval;
  emit_req_t         req;
  emit_rdy_t         rdy;

  function automatic logic eval_cond(cond_e c, logic spec, logic rem_zero,
                                     logic fit, logic has_second);
    logic r;
    unique case (c)
      COND_SPECIAL:    r = spec;
      COND_REM_ZERO:   r = rem_zero;
      COND_FITS:       r = fit;
      COND_HAS_SECOND: r = has_second;
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

  // Fetch the control word for this step
  assign uw = ucode_rom(upc_q);

  assign tval    = {2'b00, tbl_val(idx_q)};
  assign fits    = rem_q >= tval;
  assign special = (value_i == '0) || (value_i > VALUE_MAX);

  assign take_a = eval_cond(uw.cond_a, special, rem_q == '0, fits,
                            tbl_second(idx_q) != CH_NONE);
  assign take_b = eval_cond(uw.cond_b, special, rem_q == '0, fits,
                            tbl_second(idx_q) != CH_NONE);

  // Hold the step until its side condition is met
  always_comb begin
    unique case (uw.op)
      OP_LOAD:              go = in_valid_i;
      OP_FIRST, OP_SECOND:  go = rdy.char_rdy;
      OP_FLUSH, OP_FLAG:    go = rdy.res_rdy;
      default:              go = 1'b1;
    endcase
  end

  assign in_ready_o = (uw.op == OP_LOAD);

  always_comb begin
    if (!go) begin
      upc_d = upc_q;
    end else if (take_a) begin
      upc_d = uw.tgt_a;
    end else if (take_b) begin
      upc_d = uw.tgt_b;
    end else begin
      upc_d = uw.nxt;
    end
  end

  // Datapath: remainder, table index and range flag
  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    oor_d = oor_q;
    if (go) begin
      unique case (uw.op)
        OP_LOAD: begin
          rem_d = value_i;
          idx_d = IDX_TOP;
          oor_d = value_i > VALUE_MAX;
        end
        OP_TEST: begin
          if (!take_a && !take_b && idx_q != '0) begin
            idx_d = idx_q - 1'b1;
          end
        end
        OP_FIRST: begin
          rem_d = rem_q - tval;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req.char_vld = (uw.op == OP_FIRST) || (uw.op == OP_SECOND);
    req.flush    = (uw.op == OP_FLUSH);
    req.flag     = (uw.op == OP_FLAG);
    req.oor      = oor_q;
    req.sym      = (uw.op == OP_SECOND) ? tbl_second(idx_q) : tbl_first(idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    idx_q <= idx_d;
    oor_q <= oor_d;
  end

  itr_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .rdy_o          (rdy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .no_symbol_o    (no_symbol_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule
